// File: src/hhr_pkg.sv
`default_nettype none

package hhr_pkg;

    localparam int HUE_W = 15;
    localparam int SAT_W = 17;
    localparam int LEV_W = 17;
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic MODEL_HSV = 1'b0;
    localparam logic MODEL_HSL = 1'b1;

    // stages held inside each channel slice
    localparam int CH_STAGES = 5;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    typedef struct packed {
        logic                 model;
        logic [CH_STAGES-1:0] en;
    } t_pipe_ctl;

    // hue position width for one full turn
    function automatic int w_hue(int b);
        return $clog2(360 << b);
    endfunction

    // signed width of min(L, 1-L)
    function automatic int w_mm(int f);
        return ((f > LEV_W) ? f : LEV_W) + 2;
    endfunction

    // signed width of sat * level term
    function automatic int w_g(int f);
        return SAT_W + 1 + w_mm(f);
    endfunction

    // sector offset in half-sector units for the HSV or HSL model
    function automatic int unsigned ofs_half(logic model, t_chan ch);
        int unsigned r;
        r = 0;
        if (model == MODEL_HSV) begin
            case (ch)
                CH_RED:   r = 10;
                CH_GREEN: r = 6;
                CH_BLUE:  r = 2;
                default:  r = 0;
            endcase
        end else begin
            case (ch)
                CH_RED:   r = 0;
                CH_GREEN: r = 8;
                CH_BLUE:  r = 4;
                default:  r = 0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/hhr_chan.sv
`default_nettype none

module hhr_chan #(
    parameter int            FRAC_BITS       = 16,
    parameter int            HUE_SUBDEG_BITS = 6,
    parameter hhr_pkg::t_chan CH             = hhr_pkg::CH_RED,
    localparam int           W_H             = hhr_pkg::w_hue(HUE_SUBDEG_BITS),
    localparam int           W_G             = hhr_pkg::w_g(FRAC_BITS)
) (
    input  wire logic                        i_clk,
    input  wire hhr_pkg::t_pipe_ctl          i_ctl,
    input  wire logic [W_H-1:0]              i_hm,
    input  wire logic signed [W_G-1:0]       i_g,
    input  wire logic [hhr_pkg::LEV_W-1:0]   i_lev,
    output logic [hhr_pkg::PIX_W-1:0]        o_pix
);
    import hhr_pkg::*;

    localparam int D     = 60 << HUE_SUBDEG_BITS;
    localparam int DH    = 30 << HUE_SUBDEG_BITS;
    localparam int P     = 360 << HUE_SUBDEG_BITS;
    localparam int W_K   = W_H + 1;
    localparam int W_A   = W_H + 2;
    localparam int W_D   = $clog2(D + 1);
    localparam int W_T   = W_D + 1;
    localparam int W_P   = LEV_W + W_D + FRAC_BITS;
    localparam int W_M   = W_G + W_T;
    localparam int W_NUM = (((W_P + 1) > W_M) ? (W_P + 1) : W_M) + 1;
    localparam int W_SUM = W_NUM + 5;
    localparam int S_HSV = 2 * FRAC_BITS + HUE_SUBDEG_BITS + 2;
    localparam int S_HSL = 2 * FRAC_BITS + HUE_SUBDEG_BITS + 1;

    // sector position
    logic [W_K-1:0] n_ksum;
    logic [W_K-1:0] n_kwrap;
    logic [W_H-1:0] r_k;
    logic signed [W_G-1:0] r4_g;
    logic [LEV_W-1:0] r4_lev;

    always_comb begin
        n_ksum  = W_K'(ofs_half(i_ctl.model, CH) * DH) + W_K'(i_hm);
        n_kwrap = (n_ksum >= W_K'(P)) ? (n_ksum - W_K'(P)) : n_ksum;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_k    <= n_kwrap[W_H-1:0];
            r4_g   <= i_g;
            r4_lev <= i_lev;
        end
    end

    // triangle term
    logic signed [W_A-1:0] s_k, s_a, s_b, s_mn, s_lo, s_hi, s_t;
    logic signed [W_T-1:0] r_t;
    logic signed [W_G-1:0] r5_g;
    logic [LEV_W-1:0] r5_lev;

    always_comb begin
        s_k  = signed'({2'b00, r_k});
        s_a  = s_k - ((i_ctl.model == MODEL_HSL) ? W_A'(3 * DH) : W_A'(0));
        s_b  = ((i_ctl.model == MODEL_HSL) ? W_A'(9 * DH) : W_A'(4 * D)) - s_k;
        s_lo = (i_ctl.model == MODEL_HSL) ? -W_A'(DH) : W_A'(0);
        s_hi = (i_ctl.model == MODEL_HSL) ? W_A'(DH) : W_A'(D);
        s_mn = (s_a < s_b) ? s_a : s_b;
        if (s_mn < s_lo) begin
            s_t = s_lo;
        end else if (s_mn > s_hi) begin
            s_t = s_hi;
        end else begin
            s_t = s_mn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_t    <= s_t[W_T-1:0];
            r5_g   <= r4_g;
            r5_lev <= r4_lev;
        end
    end

    // products
    logic [W_D-1:0] n_dsel;
    logic [W_P-1:0] n_lp;
    logic [W_P-1:0] r_p;
    logic signed [W_M-1:0] n_m;
    logic signed [W_M-1:0] r_m;

    always_comb begin
        n_dsel = (i_ctl.model == MODEL_HSL) ? W_D'(DH) : W_D'(D);
        n_lp   = W_P'(r5_lev) * W_P'(n_dsel);
        n_m    = W_M'(r5_g) * W_M'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_p <= n_lp << FRAC_BITS;
            r_m <= n_m;
        end
    end

    // numerator
    logic signed [W_P:0]     s_p;
    logic signed [W_NUM-1:0] r_num;

    assign s_p = signed'({1'b0, r_p});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_num <= W_NUM'(s_p) - W_NUM'(r_m);
        end
    end

    // scale by 17, round half up, clamp
    logic [W_SUM-1:0] n_mag, n_half, n_sum, n_q;
    logic [PIX_W-1:0] n_pix;
    logic [PIX_W-1:0] r_pix;

    always_comb begin
        n_mag  = W_SUM'(unsigned'(r_num));
        n_half = (i_ctl.model == MODEL_HSL) ? (W_SUM'(1) << (S_HSL - 1))
                                            : (W_SUM'(1) << (S_HSV - 1));
        n_sum  = (n_mag << 4) + n_mag + n_half;
        n_q    = (i_ctl.model == MODEL_HSL) ? (n_sum >> S_HSL) : (n_sum >> S_HSV);
        if (r_num <= 0) begin
            n_pix = '0;
        end else if (n_q > W_SUM'(PIX_MAX)) begin
            n_pix = PIX_MAX;
        end else begin
            n_pix = n_q[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

`default_nettype wire

// File: src/hsv_hsl_to_rgb_core.sv
`default_nettype none

// Throughput: one word per cycle while the output is not stalled; bubbles collapse while it is stalled.
// Stage depth is set by the hue reduction (reciprocal multiply, constant
// multiply, wrap) and the per-channel sector, triangle, product, numerator and rounding steps.
// Reset (synchronous, active low) empties the pipeline and selects HSV.
module hsv_hsl_to_rgb_core #(
    parameter int FRAC_BITS       = 16,
    parameter int HUE_SUBDEG_BITS = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic                       i_cfg_wr_data,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [hhr_pkg::HUE_W-1:0]  i_hue_angle,
    input  wire logic [hhr_pkg::SAT_W-1:0]  i_sat_fraction,
    input  wire logic [hhr_pkg::LEV_W-1:0]  i_level_fraction,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [hhr_pkg::PIX_W-1:0]       o_red_out,
    output logic [hhr_pkg::PIX_W-1:0]       o_green_out,
    output logic [hhr_pkg::PIX_W-1:0]       o_blue_out
);
    import hhr_pkg::*;

    localparam int P          = 360 << HUE_SUBDEG_BITS;
    localparam int W_H        = w_hue(HUE_SUBDEG_BITS);
    localparam int SH         = HUE_W + W_H;
    localparam int W_R        = 17;
    localparam int W_PROD     = HUE_W + W_R;
    localparam int W_QP       = 36;
    localparam int W_MM       = w_mm(FRAC_BITS);
    localparam int W_G        = w_g(FRAC_BITS);
    localparam int NUM_STAGES = 8;
    localparam int PRE_STAGES = NUM_STAGES - CH_STAGES;

    localparam logic [63:0]           RECIP = (64'd1 << SH) / 64'(P);
    localparam logic signed [W_MM-1:0] ONE  = W_MM'(1) << FRAC_BITS;

    logic r_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_HSV;
        end else if (i_cfg_wr_en) begin
            r_model <= i_cfg_wr_data;
        end
    end

    // valid chain, a stage moves when the one after it is empty or moving
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld = {r_vld[NUM_STAGES-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // stage 1: hue quotient estimate, min(L, 1-L)
    logic [W_PROD-1:0]      n1_prod;
    logic signed [W_MM-1:0] s_lev, s_olev, n1_mm;
    logic [HUE_W-1:0]       r1_h, r1_q;
    logic [SAT_W-1:0]       r1_sat;
    logic [LEV_W-1:0]       r1_lev;
    logic signed [W_MM-1:0] r1_mm;

    always_comb begin
        n1_prod = W_PROD'(i_hue_angle) * W_PROD'(RECIP[W_R-1:0]);
        s_lev   = signed'(W_MM'(i_level_fraction));
        s_olev  = ONE - s_lev;
        n1_mm   = (s_lev < s_olev) ? s_lev : s_olev;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_h   <= i_hue_angle;
            r1_q   <= HUE_W'(n1_prod >> SH);
            r1_sat <= i_sat_fraction;
            r1_lev <= i_level_fraction;
            r1_mm  <= n1_mm;
        end
    end

    // stage 2: remainder estimate, saturation product
    logic [W_QP-1:0]        n2_rest;
    logic signed [W_MM-1:0] s_op;
    logic signed [W_G-1:0]  n2_g;
    logic [W_H:0]           r2_rest;
    logic signed [W_G-1:0]  r2_g;
    logic [LEV_W-1:0]       r2_lev;

    always_comb begin
        n2_rest = W_QP'(r1_h) - (W_QP'(r1_q) * W_QP'(P));
        s_op    = (r_model == MODEL_HSL) ? r1_mm : signed'(W_MM'(r1_lev));
        n2_g    = W_G'(signed'({1'b0, r1_sat})) * W_G'(s_op);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_rest <= n2_rest[W_H:0];
            r2_g    <= n2_g;
            r2_lev  <= r1_lev;
        end
    end

    // stage 3: hue wrapped into one turn
    logic [W_H:0]          n3_hm;
    logic [W_H-1:0]        r3_hm;
    logic signed [W_G-1:0] r3_g;
    logic [LEV_W-1:0]      r3_lev;

    assign n3_hm = (r2_rest >= (W_H+1)'(P)) ? (r2_rest - (W_H+1)'(P)) : r2_rest;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_hm  <= n3_hm[W_H-1:0];
            r3_g   <= r2_g;
            r3_lev <= r2_lev;
        end
    end

    t_pipe_ctl ctl;

    always_comb begin
        ctl.model = r_model;
        ctl.en    = rdy[NUM_STAGES-1:PRE_STAGES];
    end

    hhr_chan #(
        .FRAC_BITS       (FRAC_BITS),
        .HUE_SUBDEG_BITS (HUE_SUBDEG_BITS),
        .CH              (CH_RED)
    ) u_red (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_hm  (r3_hm),
        .i_g   (r3_g),
        .i_lev (r3_lev),
        .o_pix (o_red_out)
    );

    hhr_chan #(
        .FRAC_BITS       (FRAC_BITS),
        .HUE_SUBDEG_BITS (HUE_SUBDEG_BITS),
        .CH              (CH_GREEN)
    ) u_green (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_hm  (r3_hm),
        .i_g   (r3_g),
        .i_lev (r3_lev),
        .o_pix (o_green_out)
    );

    hhr_chan #(
        .FRAC_BITS       (FRAC_BITS),
        .HUE_SUBDEG_BITS (HUE_SUBDEG_BITS),
        .CH              (CH_BLUE)
    ) u_blue (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_hm  (r3_hm),
        .i_g   (r3_g),
        .i_lev (r3_lev),
        .o_pix (o_blue_out)
    );

endmodule

`default_nettype wire

// File: src/hhr_chk.sv
`default_nettype none

module hhr_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_stall,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic [hhr_pkg::PIX_W-1:0]  o_red_out,
    input wire logic [hhr_pkg::PIX_W-1:0]  o_green_out,
    input wire logic [hhr_pkg::PIX_W-1:0]  o_blue_out
);

    // held word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out)
            && $stable(o_green_out) && $stable(o_blue_out))
        else $error("output word changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // empty output stage means every stage can move
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

endmodule

bind hsv_hsl_to_rgb_core hhr_chk u_hhr_chk (.*);

`default_nettype wire
